>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL in this folder.
// Depends on nothing; the user module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge while reset is released.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/nss_pkg.sv
// Shared constants, codes and types of the substring search block.
// Depends on nothing.
package nss_pkg;

  localparam int unsigned MAX_LEN = 256;
  localparam int unsigned AW      = $clog2(MAX_LEN);  // buffer index width
  localparam int unsigned LW      = AW + 1;           // length / position width
  localparam int unsigned DW      = 8;                // byte width

  typedef enum logic [1:0] {
    CMD_TEXT   = 2'd0,
    CMD_PAT    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_EMPTY_PAT = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic          valid;
    status_e       status;
    logic [LW-1:0] pos;
  } res_t;

endpackage

>>> rtl/core/nss_ram.sv
// Byte buffer: one write port, one read port with registered read data.
// Depends on nss_pkg.
module nss_ram (
  input  logic                    clk_i,
  input  nss_pkg::ram_req_t       req_i,
  output logic [nss_pkg::DW-1:0]  rdata_o
);

  logic [nss_pkg::DW-1:0] mem [nss_pkg::MAX_LEN];
  logic [nss_pkg::DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/nss_ctrl.sv
// Command decode, buffer lengths and the window/byte compare sequencer.
// Depends on nss_pkg; drives the two nss_ram buffers.
module nss_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [1:0]              cmd_i,
  input  logic [nss_pkg::DW-1:0]  char_value_i,
  input  logic [nss_pkg::LW-1:0]  start_pos_i,
  input  logic [nss_pkg::DW-1:0]  txt_rdata_i,
  input  logic [nss_pkg::DW-1:0]  pat_rdata_i,
  output logic                    busy_o,
  output nss_pkg::ram_req_t       txt_req_o,
  output nss_pkg::ram_req_t       pat_req_o,
  output nss_pkg::res_t           res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_CMP  = 3'b100
  } state_e;

  localparam logic [nss_pkg::LW-1:0] MaxLenL = nss_pkg::LW'(nss_pkg::MAX_LEN);

  state_e                  state_q, state_d;
  logic [nss_pkg::LW-1:0]  tlen_q, tlen_d;
  logic [nss_pkg::LW-1:0]  plen_q, plen_d;
  logic [nss_pkg::AW-1:0]  base_q, base_d;
  logic [nss_pkg::AW-1:0]  k_q, k_d;

  logic                    accept;
  logic                    txt_room, pat_room;
  logic [nss_pkg::LW:0]    start_end;   // start_pos + pattern length
  logic [nss_pkg::LW-1:0]  base_nxt;    // next window, 0-based
  logic [nss_pkg::LW:0]    next_end;    // next window end, exclusive
  logic [nss_pkg::LW-1:0]  k_nxt;

  assign accept    = start_i && (state_q == S_IDLE);
  assign busy_o    = (state_q != S_IDLE);
  assign txt_room  = (tlen_q < MaxLenL);
  assign pat_room  = (plen_q < MaxLenL);
  assign start_end = {1'b0, start_pos_i} + {1'b0, plen_q};
  assign base_nxt  = {1'b0, base_q} + nss_pkg::LW'(1);
  assign next_end  = {1'b0, base_nxt} + {1'b0, plen_q};
  assign k_nxt     = {1'b0, k_q} + nss_pkg::LW'(1);

  // Writes happen only on accepted appends, read data is used only while busy: no overlap.
  always_comb begin
    txt_req_o.we    = accept && (nss_pkg::cmd_e'(cmd_i) == nss_pkg::CMD_TEXT) && txt_room;
    txt_req_o.waddr = tlen_q[nss_pkg::AW-1:0];
    txt_req_o.wdata = char_value_i;
    txt_req_o.raddr = base_q + k_q;
    pat_req_o.we    = accept && (nss_pkg::cmd_e'(cmd_i) == nss_pkg::CMD_PAT) && pat_room;
    pat_req_o.waddr = plen_q[nss_pkg::AW-1:0];
    pat_req_o.wdata = char_value_i;
    pat_req_o.raddr = k_q;
  end

  always_comb begin
    state_d    = state_q;
    tlen_d     = tlen_q;
    plen_d     = plen_q;
    base_d     = base_q;
    k_d        = k_q;
    res_o      = '0;
    res_o.status = nss_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_o.valid = 1'b1;
          unique case (nss_pkg::cmd_e'(cmd_i))
            nss_pkg::CMD_TEXT: begin
              if (txt_room) tlen_d = tlen_q + nss_pkg::LW'(1);
              else          res_o.status = nss_pkg::ST_FULL;
            end
            nss_pkg::CMD_PAT: begin
              if (pat_room) plen_d = plen_q + nss_pkg::LW'(1);
              else          res_o.status = nss_pkg::ST_FULL;
            end
            nss_pkg::CMD_SEARCH: begin
              if (start_pos_i == '0 || start_pos_i > tlen_q) begin
                res_o.status = nss_pkg::ST_BAD_POS;
              end else if (plen_q == '0) begin
                res_o.status = nss_pkg::ST_EMPTY_PAT;
              end else if (start_end > ({1'b0, tlen_q} + (nss_pkg::LW+1)'(1))) begin
                res_o.status = nss_pkg::ST_NOT_FOUND;
              end else begin
                // hold the result and walk windows from the start position
                res_o.valid = 1'b0;
                base_d  = nss_pkg::AW'(start_pos_i - nss_pkg::LW'(1));
                k_d     = '0;
                state_d = S_RD;
              end
            end
            nss_pkg::CMD_CLEAR: begin
              tlen_d = '0;
              plen_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (txt_rdata_i == pat_rdata_i) begin
          if (k_nxt == plen_q) begin
            res_o.valid  = 1'b1;
            res_o.status = nss_pkg::ST_OK;
            res_o.pos    = base_nxt;
            state_d      = S_IDLE;
          end else begin
            k_d     = k_nxt[nss_pkg::AW-1:0];
            state_d = S_RD;
          end
        end else if (next_end <= {1'b0, tlen_q}) begin
          base_d  = base_nxt[nss_pkg::AW-1:0];
          k_d     = '0;
          state_d = S_RD;
        end else begin
          res_o.valid  = 1'b1;
          res_o.status = nss_pkg::ST_NOT_FOUND;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tlen_q  <= '0;
      plen_q  <= '0;
    end else begin
      state_q <= state_d;
      tlen_q  <= tlen_d;
      plen_q  <= plen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    k_q    <= k_d;
  end

endmodule

>>> rtl/core/naive_substring_search.sv
// Append/clear: request taken each cycle while busy_o is low, result strobed on done_o in the next cycle.
// Search: result strobed in the next cycle when no window is walked; otherwise
// busy_o stays high while the byte compares are made (one buffer read and
// one compare each), and the result is strobed in the cycle busy_o drops.
// Reset: asynchronous, active low; clears both lengths and the sequencer. The
// buffer contents stay undefined, there is no clearing pass.
`include "assert_macros.svh"

module naive_substring_search (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              cmd_i,
  input  logic [nss_pkg::DW-1:0]  char_value_i,
  input  logic [nss_pkg::LW-1:0]  start_pos_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [nss_pkg::LW-1:0]  match_position_o
);

  nss_pkg::ram_req_t       txt_req, pat_req;
  logic [nss_pkg::DW-1:0]  txt_rdata, pat_rdata;
  nss_pkg::res_t           res;

  logic                    done_q;
  nss_pkg::status_e        status_q;
  logic [nss_pkg::LW-1:0]  pos_q;

  // Sequencer: decodes requests, owns the lengths, walks windows.
  nss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .char_value_i (char_value_i),
    .start_pos_i  (start_pos_i),
    .txt_rdata_i  (txt_rdata),
    .pat_rdata_i  (pat_rdata),
    .busy_o       (busy_o),
    .txt_req_o    (txt_req),
    .pat_req_o    (pat_req),
    .res_o        (res)
  );

  // Text buffer.
  nss_ram u_txt_ram (
    .clk_i   (clk_i),
    .req_i   (txt_req),
    .rdata_o (txt_rdata)
  );

  // Pattern buffer.
  nss_ram u_pat_ram (
    .clk_i   (clk_i),
    .req_i   (pat_req),
    .rdata_o (pat_rdata)
  );

  // Result register: strobe for exactly one cycle, the receiver cannot stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  // Payload: capture only with a fresh result, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      pos_q    <= res.pos;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign match_position_o = pos_q;

  // A nonzero position only ever comes with a found status.
  `ASSERT_RST(a_pos_found, (done_o && match_position_o != '0) |-> (status_o == nss_pkg::ST_OK),
              "match position without found status")
  // Every accepted request either answers next cycle or starts a search.
  `ASSERT_RST(a_req_answered, (start_i && !busy_o) |=> (done_o || busy_o),
              "accepted request neither answered nor searching")
  // A finishing search strobes its result as busy drops.
  `ASSERT_RST(a_search_done, $fell(busy_o) |-> done_o, "search ended without result")
  // No result is strobed while a search is still walking.
  `ASSERT_ALWAYS(a_no_done_busy, busy_o |-> !done_o, "result strobed while busy")

endmodule

>>> bench/tb.sv
// Self-checking bench for naive_substring_search: loads text and pattern bytes,
// runs searches and clears, and checks every strobed answer against a predictor or a hand-written answer.
// Depends on nss_pkg and the naive_substring_search RTL only.
module tb;
  import nss_pkg::*;

  localparam int ITEMS = 1100;  // requests to send in all
  localparam int TAIL  = 150;   // final stretch sent back to back
  localparam int SHOWN = 10;    // failures printed in full

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  logic [1:0]     cmd_i;
  logic [DW-1:0]  char_value_i;
  logic [LW-1:0]  start_pos_i;
  logic           done_o;
  logic [2:0]     status_o;
  logic [LW-1:0]  match_position_o;

  naive_substring_search DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .char_value_i     (char_value_i),
    .start_pos_i      (start_pos_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .match_position_o (match_position_o)
  );

  // One answer the block owes, in request order.
  typedef struct {
    status_e       st;
    logic [LW-1:0] at;
    int            tag;
  } answer_t;

  // One row of the directed table. When given is set, st/at are the answer
  // written out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    cmd_e          cmd;
    logic [DW-1:0] ch;
    logic [LW-1:0] pos;
    logic          given;
    status_e       st;
    logic [LW-1:0] at;
  } plan_row_t;

  answer_t answers_due[$];

  // Predictor's copy of the buffers.
  logic [DW-1:0] txt_mem [MAX_LEN];
  logic [DW-1:0] pat_mem [MAX_LEN];
  int            txt_len;
  int            pat_len;

  // Hand-written answer for the request on the ports, if any.
  logic          want_given;
  status_e       want_st;
  logic [LW-1:0] want_at;

  int n_sent;
  int n_taken;
  int n_checked;
  int n_bad;
  int n_status [5];

  // Stimulus shaping.
  int            idle_pct;
  bit            noise_on;
  logic [DW-1:0] alpha [4];
  int            alpha_n;

  plan_row_t plan [24];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Generous ceiling, far above the slowest legal run.
  initial begin
    #(64'd8_000_000);
    $display("FAILURE");
    $finish;
  end

  // Work out the answer to one request and advance the buffers. A search
  // tries every window from the start position that lies fully in the text.
  function automatic void predict_answer(input cmd_e cmd, input logic [DW-1:0] ch,
                                         input logic [LW-1:0] pos,
                                         output status_e st, output logic [LW-1:0] at);
    int  i;
    int  k;
    bit  hit;
    st = ST_OK;
    at = '0;
    case (cmd)
      CMD_TEXT: begin
        if (txt_len < MAX_LEN) begin
          txt_mem[txt_len] = ch;
          txt_len++;
        end else begin
          st = ST_FULL;
        end
      end
      CMD_PAT: begin
        if (pat_len < MAX_LEN) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          st = ST_FULL;
        end
      end
      CMD_SEARCH: begin
        // Bad start wins over an empty pattern.
        if (int'(pos) < 1 || int'(pos) > txt_len) begin
          st = ST_BAD_POS;
        end else if (pat_len == 0) begin
          st = ST_EMPTY_PAT;
        end else begin
          st = ST_NOT_FOUND;
          for (i = int'(pos); i + pat_len <= txt_len + 1 && st == ST_NOT_FOUND; i++) begin
            hit = 1'b1;
            for (k = 0; k < pat_len; k++)
              if (txt_mem[i - 1 + k] != pat_mem[k]) hit = 1'b0;
            if (hit) begin
              st = ST_OK;
              at = LW'(i);
            end
          end
        end
      end
      default: begin
        txt_len = 0;
        pat_len = 0;
      end
    endcase
  endfunction

  // Sample at the rising edge: check a strobed answer first, then log a
  // request taken on this edge.
  always @(posedge clk_i) begin : watch
    status_e       st;
    logic [LW-1:0] at;
    answer_t       a;
    if (rst_ni) begin
      if (done_o) begin
        if (answers_due.size() == 0) begin
          n_bad++;
          if (n_bad <= SHOWN)
            $display("unexpected answer: status %0d position %0d", status_o, match_position_o);
        end else begin
          a = answers_due.pop_front();
          n_checked++;
          if (status_o !== a.st || match_position_o !== a.at) begin
            n_bad++;
            if (n_bad <= SHOWN)
              $display("request %0d: expected status %0d position %0d, got status %0d position %0d",
                       a.tag, a.st, a.at, status_o, match_position_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        // Always run the predictor so its buffers track the block.
        predict_answer(cmd_e'(cmd_i), char_value_i, start_pos_i, st, at);
        if (want_given) begin
          st = want_st;
          at = want_at;
        end
        answers_due.push_back('{st, at, n_taken});
        n_status[int'(st)]++;
        n_taken++;
      end
    end
  end

  // Present one request at a falling edge and hold it until it is taken.
  // Leave start_i high on return so a following request goes back to back.
  task automatic send(input cmd_e cmd, input logic [DW-1:0] ch, input logic [LW-1:0] pos,
                      input logic given, input status_e st, input logic [LW-1:0] at);
    int seen;
    seen       = n_taken;
    want_given = given;
    want_st    = st;
    want_at    = at;
    cmd_i        <= cmd;
    char_value_i <= ch;
    start_pos_i  <= pos;
    start_i      <= 1'b1;
    do @(negedge clk_i); while (n_taken == seen);
    n_sent++;
  endtask

  // Drop start, then wait; n sets the length of the gap.
  task automatic hold_off(input int n);
    start_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Drop start and wait until every owed answer has come back.
  task automatic wait_answers();
    start_i <= 1'b0;
    do @(negedge clk_i); while (answers_due.size() != 0);
  endtask

  // Idle burst now and then, never in the final stretch.
  task automatic pace();
    if (n_sent < ITEMS - TAIL && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
      hold_off($urandom_range(1, 17));
  endtask

  // Send one random-part request, sometimes preceded by a stray one.
  task automatic push(input cmd_e cmd, input logic [DW-1:0] ch, input logic [LW-1:0] pos);
    pace();
    if (noise_on && $urandom_range(0, 99) < 4) begin
      send(cmd_e'($urandom_range(0, 3)), DW'($urandom), LW'($urandom), 1'b0, ST_OK, '0);
      pace();
    end
    send(cmd, ch, pos, 1'b0, ST_OK, '0);
  endtask

  function automatic logic [DW-1:0] pick_char();
    return alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  // Mostly a legal start; sometimes zero, just past the end, or any 9-bit value.
  function automatic logic [LW-1:0] pick_start();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80 && txt_len > 0) return LW'($urandom_range(1, txt_len));
    if (r < 88) return '0;
    if (r < 93) return LW'(txt_len + 1);
    return LW'($urandom);
  endfunction

  // Short text and pattern over a small alphabet, then a few searches.
  // The pattern is often cut from the text so that matches are common.
  task automatic short_run();
    int            n_txt;
    int            n_pat;
    int            off;
    int            k;
    logic [DW-1:0] c;
    if ($urandom_range(0, 99) < 85) push(CMD_CLEAR, DW'($urandom), LW'($urandom));
    alpha_n = $urandom_range(1, 4);
    for (k = 0; k < 4; k++) alpha[k] = DW'($urandom);
    n_txt = $urandom_range(1, 24);
    n_pat = $urandom_range(1, 6);
    if ($urandom_range(0, 99) < 20) begin
      repeat (n_pat) push(CMD_PAT, pick_char(), LW'($urandom));
      repeat (n_txt) push(CMD_TEXT, pick_char(), LW'($urandom));
    end else begin
      repeat (n_txt) push(CMD_TEXT, pick_char(), LW'($urandom));
      if (txt_len >= n_pat && $urandom_range(0, 99) < 60) begin
        off = $urandom_range(0, txt_len - n_pat);
        for (k = 0; k < n_pat; k++) begin
          c = txt_mem[off + k];
          // Spoil the last byte now and then for a near miss.
          if (k == n_pat - 1 && $urandom_range(0, 99) < 20) c = pick_char();
          push(CMD_PAT, c, LW'($urandom));
        end
      end else begin
        repeat (n_pat) push(CMD_PAT, pick_char(), LW'($urandom));
      end
    end
    repeat ($urandom_range(1, 5)) push(CMD_SEARCH, DW'($urandom), pick_start());
  endtask

  // Fill the text past capacity, search with a short prefix pattern, then
  // grow the pattern past capacity and search with the full-length pattern.
  task automatic long_run();
    int n_pat;
    int k;
    noise_on = 1'b0;
    push(CMD_CLEAR, DW'($urandom), LW'($urandom));
    alpha_n  = 2;
    alpha[0] = DW'($urandom);
    alpha[1] = DW'($urandom);
    repeat (MAX_LEN + 2) push(CMD_TEXT, pick_char(), LW'($urandom));
    n_pat = $urandom_range(1, 8);
    for (k = 0; k < n_pat; k++) push(CMD_PAT, txt_mem[k], LW'($urandom));
    repeat (3) push(CMD_SEARCH, DW'($urandom), pick_start());
    push(CMD_SEARCH, DW'($urandom), LW'(MAX_LEN));
    for (k = n_pat; k < MAX_LEN + 2; k++)
      push(CMD_PAT, (k < MAX_LEN) ? txt_mem[k] : DW'($urandom), LW'($urandom));
    push(CMD_SEARCH, DW'($urandom), LW'(1));
    push(CMD_SEARCH, DW'($urandom), LW'(2));
    noise_on = 1'b1;
  endtask

  initial begin : stimulus
    int i;
    int seq;
    start_i      = 1'b0;
    cmd_i        = CMD_TEXT;
    char_value_i = '0;
    start_pos_i  = '0;
    rst_ni       = 1'b0;
    want_given   = 1'b0;
    want_st      = ST_OK;
    want_at      = '0;
    txt_len      = 0;
    pat_len      = 0;
    n_sent       = 0;
    n_taken      = 0;
    n_checked    = 0;
    n_bad        = 0;
    for (i = 0; i < 5; i++) n_status[i] = 0;
    idle_pct     = 0;
    noise_on     = 1'b1;
    alpha_n      = 1;
    for (i = 0; i < 4; i++) alpha[i] = '0;

    // Text ends up 00 FF 00 FF; pattern FF 00, then FF 00 FF 00 FF.
    plan = '{
      '{CMD_SEARCH, 8'h00, 9'd0,   1'b1, ST_BAD_POS,   9'd0},  // start of zero
      '{CMD_SEARCH, 8'h00, 9'd1,   1'b1, ST_BAD_POS,   9'd0},  // text still empty
      '{CMD_TEXT,   8'h00, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_TEXT,   8'hFF, 9'd511, 1'b1, ST_OK,        9'd0},
      '{CMD_TEXT,   8'h00, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_TEXT,   8'hFF, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_SEARCH, 8'hFF, 9'd1,   1'b1, ST_EMPTY_PAT, 9'd0},  // no pattern yet
      '{CMD_SEARCH, 8'h00, 9'd5,   1'b1, ST_BAD_POS,   9'd0},  // just past the text
      '{CMD_SEARCH, 8'h00, 9'd511, 1'b1, ST_BAD_POS,   9'd0},
      '{CMD_PAT,    8'hFF, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_PAT,    8'h00, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_SEARCH, 8'h00, 9'd1,   1'b0, ST_OK,        9'd0},
      '{CMD_SEARCH, 8'h00, 9'd3,   1'b0, ST_OK,        9'd0},
      '{CMD_SEARCH, 8'h00, 9'd4,   1'b0, ST_OK,        9'd0},  // pattern runs off the end
      '{CMD_PAT,    8'hFF, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_PAT,    8'h00, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_PAT,    8'hFF, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_SEARCH, 8'h00, 9'd1,   1'b0, ST_OK,        9'd0},  // pattern longer than text
      '{CMD_CLEAR,  8'h00, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_SEARCH, 8'h00, 9'd1,   1'b1, ST_BAD_POS,   9'd0},  // cleared text
      '{CMD_PAT,    8'h5A, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_TEXT,   8'h5A, 9'd0,   1'b1, ST_OK,        9'd0},
      '{CMD_SEARCH, 8'h00, 9'd1,   1'b0, ST_OK,        9'd0},
      '{CMD_SEARCH, 8'h00, 9'd256, 1'b1, ST_BAD_POS,   9'd0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, with the odd gap between rows.
    for (i = 0; i < 24; i++) begin
      send(plan[i].cmd, plan[i].ch, plan[i].pos, plan[i].given, plan[i].st, plan[i].at);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 17));
    end

    // Let the block run dry once before the random part.
    wait_answers();

    // Random part: short sequences, one long fill run, and a drain now and then
    // outside the final stretch.
    seq = 0;
    while (n_sent < ITEMS) begin
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 30;
        default: idle_pct = 60;
      endcase
      if (seq == 2) long_run();
      else          short_run();
      if (n_sent < ITEMS - TAIL && $urandom_range(0, 9) == 0) wait_answers();
      seq++;
    end

    // Drain, then give a stray strobe time to show up.
    wait_answers();
    repeat (16) @(negedge clk_i);
    n_bad += answers_due.size();

    $display("%0d requests: %0d ok/found, %0d not found, %0d bad start, %0d empty pattern, %0d full",
             n_taken, n_status[int'(ST_OK)], n_status[int'(ST_NOT_FOUND)],
             n_status[int'(ST_BAD_POS)], n_status[int'(ST_EMPTY_PAT)], n_status[int'(ST_FULL)]);
    $display("%0d answers checked, %0d failures", n_checked, n_bad);
    if (n_bad == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
